/* rtl/sha1_digest_base64_macros.svh */
// Assertion helpers used by the checker file.
`ifndef SHA1_DIGEST_BASE64_MACROS_SVH
`define SHA1_DIGEST_BASE64_MACROS_SVH

// Same-cycle implication, switched off during reset.
`define SB_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, switched off during reset.
`define SB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define SB_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/sha1b64_pkg.sv */
`default_nettype none
package sha1b64_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_last;
   } rsp_type;

   // control from the sequencer to the round unit
   typedef struct packed {
      logic byte_wr;
      logic start;
      logic chain_init;
   } rnd_ctl_type;

   localparam logic [159:0] SHA_IV = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                      32'h10325476, 32'hC3D2E1F0};
   localparam logic [31:0] K_R0 = 32'h5A827999;
   localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_R3 = 32'hCA62C1D6;

   localparam logic [6:0] ROUND_LAST = 7'd79;
   localparam logic [6:0] ROUND_B1   = 7'd20;
   localparam logic [6:0] ROUND_B2   = 7'd40;
   localparam logic [6:0] ROUND_B3   = 7'd60;

   localparam logic [7:0] PAD_MARK    = 8'h80;
   localparam logic [5:0] LEN_POS     = 6'd56;
   localparam logic [2:0] LEN_IDX_END = 3'd7;

   localparam logic [4:0] CHAR_LAST_IDX = 5'd27;
   localparam logic [7:0] CHAR_PAD      = 8'h3D; // '='

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] r;
      if (v < 6'd26) begin
         r = 8'h41 + {2'b00, v};          // 'A'..
      end else if (v < 6'd52) begin
         r = 8'h47 + {2'b00, v};          // 'a' - 26
      end else if (v < 6'd62) begin
         r = {2'b00, v} - 8'h04;          // '0' - 52
      end else if (v == 6'd62) begin
         r = 8'h2B;                       // '+'
      end else begin
         r = 8'h2F;                       // '/'
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/sha1b64_round.sv */
`default_nettype none
module sha1b64_round import sha1b64_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire rnd_ctl_type  ctl,
   input  wire logic [7:0]   byte_in,
   output logic              done,
   output logic [159:0]      chain
);

   // schedule as a 512-bit line; top word is the current W[t]
   logic [511:0] sched_ff, sched_in;
   logic [159:0] chain_ff, chain_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  a_in, b_in, c_in, d_in, e_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         run_ff, run_in;
   logic         fin_ff, fin_in;

   logic [31:0] w_cur, w_mix, f_val, k_val, t_sum;

   always_comb begin
      w_cur = sched_ff[511:480];
      w_mix = sched_ff[95:64] ^ sched_ff[255:224] ^ sched_ff[447:416] ^ sched_ff[511:480];
      if (cnt_ff < ROUND_B1) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_R0;
      end else if (cnt_ff < ROUND_B2) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_R1;
      end else if (cnt_ff < ROUND_B3) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_R2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_R3;
      end
      t_sum = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_cur;
   end

   always_comb begin
      sched_in = sched_ff;
      chain_in = chain_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      fin_in   = 1'b0;
      if (ctl.byte_wr) begin
         sched_in = {sched_ff[503:0], byte_in};
      end
      if (ctl.start) begin
         {a_in, b_in, c_in, d_in, e_in} = chain_ff;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         a_in     = t_sum;
         b_in     = a_ff;
         c_in     = {b_ff[1:0], b_ff[31:2]};
         d_in     = c_ff;
         e_in     = d_ff;
         sched_in = {sched_ff[479:0], w_mix[30:0], w_mix[31]};
         cnt_in   = cnt_ff + 7'd1;
         if (cnt_ff == ROUND_LAST) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
      if (fin_ff) begin
         chain_in = {chain_ff[159:128] + a_ff, chain_ff[127:96] + b_ff,
                     chain_ff[95:64] + c_ff, chain_ff[63:32] + d_ff,
                     chain_ff[31:0] + e_ff};
      end
      if (ctl.chain_init) begin
         chain_in = SHA_IV;
      end
   end

   always_ff @(posedge clock) begin
      sched_ff <= sched_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         chain_ff <= SHA_IV;
         run_ff   <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         chain_ff <= chain_in;
         run_ff   <= run_in;
         fin_ff   <= fin_in;
      end
   end

   assign done  = fin_ff;
   assign chain = chain_ff;

endmodule
`default_nettype wire

/* rtl/sha1b64_enc.sv */
`default_nettype none
module sha1b64_enc import sha1b64_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           load,
   input  wire logic [159:0]   digest,
   output logic                busy,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output rsp_type             rsp_payload
);

   // digest plus two zero bits gives 27 sextets
   logic [161:0] bits_ff, bits_in;
   logic [4:0]   idx_ff, idx_in;
   logic         busy_ff, busy_in;
   logic         valid_ff, valid_in;
   rsp_type      out_ff, out_in;
   logic         advance;

   always_comb begin
      advance  = busy_ff && (!valid_ff || !rsp_stall);
      bits_in  = bits_ff;
      idx_in   = idx_ff;
      busy_in  = busy_ff;
      out_in   = out_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         bits_in = {digest, 2'b00};
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (advance) begin
         valid_in         = 1'b1;
         out_in.char_last = (idx_ff == CHAR_LAST_IDX);
         out_in.out_char  = (idx_ff == CHAR_LAST_IDX) ? CHAR_PAD : b64_char(bits_ff[161:156]);
         bits_in          = {bits_ff[155:0], 6'b000000};
         idx_in           = idx_ff + 5'd1;
         if (idx_ff == CHAR_LAST_IDX) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      idx_ff  <= idx_in;
      out_ff  <= out_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign busy        = busy_ff;
   assign rsp_valid   = valid_ff;
   assign rsp_payload = out_ff;

endmodule
`default_nettype wire

/* rtl/sha1_digest_base64.sv */
`default_nettype none
// SHA-1 over a byte stream, digest delivered as base64 text.
// req_ channel: one item per accepted handshake (req_valid high, req_stall low).
//   An item may carry one message byte (byte_present) and may close the
//   message (message_end); an end item without a byte is allowed.
// rsp_ channel: 28 items per message, 27 base64 characters then '=',
//   char_last set on the '='. Nothing comes out for items without message_end.
// Timing: the 64th byte of a block starts a compression: the 80 rounds of
//   the single shared round unit, then the chaining add. A message end adds
//   padding and one or two compressions, then hands the digest to the
//   encoder; characters follow one per cycle while rsp_stall is low. The
//   request side is stalled from the compression or padding until the hand-over.
// The output register lets the next message start while characters still wait.
// A stalled rsp_ item holds its value; the encoder simply waits.
// Reset (synchronous) restores the initial chaining values, clears the length
// and fill counters and drops any pending output.
module sha1_digest_base64 import sha1b64_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_PAD    = 4'b0010,
      ST_COMP   = 4'b0100,
      ST_DIGEST = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic [60:0]   total_ff, total_in;
   logic [5:0]    fill_ff, fill_in;
   logic          end_ff, end_in;
   logic          first_ff, first_in;
   logic          len_ff, len_in;
   logic [2:0]    lidx_ff, lidx_in;
   logic          pdone_ff, pdone_in;

   rnd_ctl_type   ctl;
   logic [7:0]    byte_sel;
   logic          rnd_done;
   logic [159:0]  chain;
   logic          enc_load;
   logic          enc_busy;
   logic [5:0]    fill_inc;
   logic [63:0]   bit_len;
   logic          len_now;
   logic          accept;

   always_comb begin
      fill_inc = fill_ff + 6'd1;
      bit_len  = {total_ff, 3'b000};
      len_now  = len_ff || (!first_ff && (fill_ff == LEN_POS));
      accept   = req_valid && !req_stall;
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      fill_in  = fill_ff;
      end_in   = end_ff;
      first_in = first_ff;
      len_in   = len_ff;
      lidx_in  = lidx_ff;
      pdone_in = pdone_ff;
      ctl      = '0;
      byte_sel = req_payload.data_byte;
      enc_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               end_in   = req_payload.message_end;
               first_in = 1'b1;
               if (req_payload.byte_present) begin
                  ctl.byte_wr = 1'b1;
                  total_in    = total_ff + 61'd1;
                  fill_in     = fill_inc;
               end
               if (req_payload.byte_present && (fill_inc == '0)) begin
                  ctl.start = 1'b1;
                  state_in  = ST_COMP;
               end else if (req_payload.message_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (first_ff) begin
               byte_sel = PAD_MARK;
            end else if (len_now) begin
               byte_sel = bit_len[{~lidx_ff, 3'b000} +: 8];
            end else begin
               byte_sel = '0;
            end
            ctl.byte_wr = 1'b1;
            fill_in     = fill_inc;
            first_in    = 1'b0;
            len_in      = len_now;
            if (len_now && !first_ff) begin
               lidx_in = lidx_ff + 3'd1;
               if (lidx_ff == LEN_IDX_END) begin
                  pdone_in = 1'b1;
               end
            end
            if (fill_inc == '0) begin
               ctl.start = 1'b1;
               state_in  = ST_COMP;
            end
         end
         ST_COMP: begin
            if (rnd_done) begin
               if (pdone_ff) begin
                  state_in = ST_DIGEST;
               end else if (end_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIGEST: begin
            if (!enc_busy) begin
               enc_load       = 1'b1;
               ctl.chain_init = 1'b1;
               total_in       = '0;
               fill_in        = '0;
               end_in         = 1'b0;
               len_in         = 1'b0;
               lidx_in        = '0;
               pdone_in       = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         fill_ff  <= '0;
         end_ff   <= 1'b0;
         first_ff <= 1'b0;
         len_ff   <= 1'b0;
         lidx_ff  <= '0;
         pdone_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         fill_ff  <= fill_in;
         end_ff   <= end_in;
         first_ff <= first_in;
         len_ff   <= len_in;
         lidx_ff  <= lidx_in;
         pdone_ff <= pdone_in;
      end
   end

   sha1b64_round u_round (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .byte_in (byte_sel),
      .done    (rnd_done),
      .chain   (chain)
   );

   sha1b64_enc u_enc (
      .clock       (clock),
      .reset       (reset),
      .load        (enc_load),
      .digest      (chain),
      .busy        (enc_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

/* rtl/sha1b64_chk.sv */
`default_nettype none
`include "sha1_digest_base64_macros.svh"
module sha1b64_chk import sha1b64_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_payload,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   logic [7:0] ch;
   logic       is_b64;
   logic       req_hs;

   assign ch     = rsp_payload.out_char;
   assign is_b64 = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
                   (ch >= 8'h30 && ch <= 8'h39) || (ch == 8'h2B) || (ch == 8'h2F);
   assign req_hs = req_valid && !req_stall && req_payload.byte_present;

   `SB_ASSERT_ALWAYS(a_rsp_clear_after_reset, reset, !rsp_valid)
   `SB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `SB_ASSERT_NOW(a_last_is_pad, rsp_valid, rsp_payload.char_last == (ch == CHAR_PAD))
   `SB_ASSERT_NOW(a_char_alphabet, rsp_valid && !rsp_payload.char_last && req_hs, is_b64)

endmodule

bind sha1_digest_base64 sha1b64_chk u_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
module tb;
   import sha1b64_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_ITEMS = 180;
   localparam int DRAIN_CYCLES = 300;
   localparam int MAX_REPORTS  = 40;
   localparam int DIGEST_CHARS = 28;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
   localparam logic [31:0] K_CH    = 32'h5A827999;
   localparam logic [31:0] K_PAR1  = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJ   = 32'h8F1BBCDC;
   localparam logic [31:0] K_PAR2  = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_MARKER = 8'h80;
   localparam logic [5:0]  LENGTH_SLOT = 6'd56;
   localparam logic [7:0]  EQUALS_CHAR = 8'h3D;
   localparam logic [8*64-1:0] B64_SET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef logic [7:0] byte_list_type[$];

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // hash state mirrored from accepted items
   logic [31:0] hash_h [5];
   logic [31:0] sched_w [16];
   logic [60:0] msg_bytes;
   logic [5:0]  blk_fill;
   rsp_type     digest_chars_q [$];

   int error_count = 0;
   int chars_checked = 0;
   int digests_done = 0;
   int items_sent = 0;
   int ignored_sent = 0;
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   int stall_left = 0;
   int cycle_no = 0;

   sha1_digest_base64 dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("Timeout: %0d chars still awaited", digest_chars_q.size());
      $display("Test completed with failures");
      $finish;
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
   endtask

   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [7:0] b64_symbol(input logic [5:0] v);
      return B64_SET[8 * (63 - int'(v)) +: 8];
   endfunction

   function automatic void hash_restart();
      hash_h[0] = H0_INIT;
      hash_h[1] = H1_INIT;
      hash_h[2] = H2_INIT;
      hash_h[3] = H3_INIT;
      hash_h[4] = H4_INIT;
      msg_bytes = '0;
      blk_fill  = '0;
   endfunction

   function automatic void sha1_compress();
      logic [31:0] a, b, c, d, e, f, k, w, sum;
      a = hash_h[0];
      b = hash_h[1];
      c = hash_h[2];
      d = hash_h[3];
      e = hash_h[4];
      for (int t = 0; t < 80; t++) begin
         // schedule is a 16-word ring, expanded in place
         if (t >= 16) begin
            w = sched_w[(t + 13) % 16] ^ sched_w[(t + 8) % 16]
                ^ sched_w[(t + 2) % 16] ^ sched_w[t % 16];
            sched_w[t % 16] = rol32(w, 1);
         end
         w = sched_w[t % 16];
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = K_CH;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = K_PAR1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_MAJ;
         end else begin
            f = b ^ c ^ d;
            k = K_PAR2;
         end
         sum = rol32(a, 5) + f + e + k + w;
         e = d;
         d = c;
         c = rol32(b, 30);
         b = a;
         a = sum;
      end
      hash_h[0] += a;
      hash_h[1] += b;
      hash_h[2] += c;
      hash_h[3] += d;
      hash_h[4] += e;
   endfunction

   function automatic void absorb_byte(input logic [7:0] value);
      if (blk_fill[1:0] == 2'd0) begin
         sched_w[blk_fill[5:2]] = '0;
      end
      sched_w[blk_fill[5:2]][8 * (3 - int'(blk_fill[1:0])) +: 8] = value;
      blk_fill = blk_fill + 6'd1;
      if (blk_fill == 6'd0) begin
         sha1_compress();
      end
   endfunction

   function automatic void close_message();
      logic [63:0]  bit_len;
      logic [167:0] sextets;
      rsp_type      ch;
      bit_len = {msg_bytes, 3'b000};
      absorb_byte(PAD_MARKER);
      while (blk_fill != LENGTH_SLOT) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) begin
         absorb_byte(bit_len[63 - 8 * i -: 8]);
      end
      // 160 digest bits plus 8 zero bits make 28 sextets; the last becomes '='
      sextets = {hash_h[0], hash_h[1], hash_h[2], hash_h[3], hash_h[4], 8'h00};
      for (int i = 0; i < DIGEST_CHARS - 1; i++) begin
         ch.out_char  = b64_symbol(sextets[167 - 6 * i -: 6]);
         ch.char_last = 1'b0;
         digest_chars_q.push_back(ch);
      end
      ch.out_char  = EQUALS_CHAR;
      ch.char_last = 1'b1;
      digest_chars_q.push_back(ch);
      digests_done++;
      hash_restart();
   endfunction

   function automatic void predict_item(input req_type item);
      if (item.byte_present) begin
         msg_bytes = msg_bytes + 61'd1;
         absorb_byte(item.data_byte);
      end
      if (item.message_end) begin
         close_message();
      end
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      gap = req_quiet ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(item);
      if (item.byte_present || item.message_end) begin
         items_sent++;
      end else begin
         ignored_sent++;
      end
   endtask

   // Sends the bytes, with optional filler items that carry no byte, and
   // closes the message either on the last byte or with a bare end item.
   task automatic send_message(input byte_list_type bytes, input bit end_on_byte,
                               input int noise_pct);
      req_type item;
      req_quiet = ($urandom_range(0, 3) == 0);
      foreach (bytes[i]) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            item.data_byte    = 8'($urandom);
            item.byte_present = 1'b0;
            item.message_end  = 1'b0;
            send_item(item);
         end
         item.data_byte    = bytes[i];
         item.byte_present = 1'b1;
         item.message_end  = end_on_byte && (i == bytes.size() - 1);
         send_item(item);
      end
      if (!end_on_byte || bytes.size() == 0) begin
         item.data_byte    = 8'($urandom);
         item.byte_present = 1'b0;
         item.message_end  = 1'b1;
         send_item(item);
      end
   endtask

   function automatic byte_list_type random_bytes(input int len);
      byte_list_type q;
      for (int i = 0; i < len; i++) q.push_back(8'($urandom));
      return q;
   endfunction

   task automatic test_empty_message();
      byte_list_type none;
      send_message(none, 1'b0, 0);
   endtask

   task automatic test_single_byte();
      send_message('{8'hFF}, 1'b1, 0);
      send_message('{8'h00}, 1'b1, 0);
   endtask

   task automatic test_abc();
      send_message('{8'h61, 8'h62, 8'h63}, 1'b0, 50);
   endtask

   task automatic test_padding_edges();
      // 56 bytes forces a second padding block; 64 fills a block exactly
      send_message(random_bytes(56), 1'b0, 5);
      send_message(random_bytes(64), 1'b1, 5);
   endtask

   task automatic test_random_messages(input int start_count);
      int roll, len;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 9);
         if (roll < 7) begin
            len = $urandom_range(0, 16);
         end else if (roll < 9) begin
            len = $urandom_range(17, 40);
         end else begin
            case ($urandom_range(0, 3))
               0: len = 55;
               1: len = 57;
               2: len = 63;
               default: len = 65;
            endcase
         end
         send_message(random_bytes(len), 1'($urandom), 10);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      int hold;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_chars_q.size() == 0) begin
            report_error($sformatf("char 0x%02h last=%0b with none expected",
                                   rsp_payload.out_char, rsp_payload.char_last));
         end else begin
            want = digest_chars_q.pop_front();
            if (rsp_payload.out_char !== want.out_char) begin
               report_error($sformatf("out_char 0x%02h, expected 0x%02h",
                                      rsp_payload.out_char, want.out_char));
            end
            if (rsp_payload.char_last !== want.char_last) begin
               report_error($sformatf("char_last %0b, expected %0b",
                                      rsp_payload.char_last, want.char_last));
            end
            chars_checked++;
         end
      end
      if (cycle_no % 300 == 0) begin
         rsp_quiet = ($urandom_range(0, 3) == 0);
      end
      cycle_no++;
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         hold = idle_gap();
         if (rsp_quiet || hold == 0) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left = hold - 1;
            rsp_stall <= 1'b1;
         end
      end
   end

   initial begin
      int directed_count;
      hash_restart();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_empty_message();
      test_single_byte();
      test_abc();
      directed_count = items_sent;
      test_padding_edges();
      test_random_messages(directed_count);

      req_valid <= 1'b0;
      while (digest_chars_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d message items and %0d filler items over %0d messages,",
               items_sent, ignored_sent, digests_done);
      $display("checked %0d digest characters, %0d mismatches.",
               chars_checked, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
